[rtl/dloe_pkg.sv]
`default_nettype none

package dloe_pkg;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_CODE   = 3'd1,
		PH_LEN    = 3'd2,
		PH_DATA   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CAP_GEO   = 2'd0,
		CAP_CIVIC = 2'd1,
		CAP_NONE  = 2'd3
	} cap_t;

	localparam logic [1:0] KIND_GEO    = 2'd0;
	localparam logic [1:0] KIND_CIVIC  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	localparam logic [7:0] END_OPTION = 8'd255;
	localparam logic [7:0] PAD_OPTION = 8'd0;
	localparam logic [7:0] WINDOW_FILL = 8'd3;

	localparam logic [1:0] REG_COOKIE  = 2'd0;
	localparam logic [1:0] REG_GEO     = 2'd1;
	localparam logic [1:0] REG_CIVIC   = 2'd2;
	localparam logic [1:0] REG_MIN_LEN = 2'd3;

	localparam logic [31:0] COOKIE_RESET  = 32'h6382_5363;
	localparam logic [7:0]  GEO_RESET     = 8'd123;
	localparam logic [7:0]  CIVIC_RESET   = 8'd99;
	localparam logic [7:0]  MIN_LEN_RESET = 8'd236;

	typedef struct packed {
		logic [31:0] cookie;
		logic [7:0]  geo_code;
		logic [7:0]  civic_code;
		logic [7:0]  min_len;
	} cfg_t;

	typedef struct packed {
		logic       pay_v;
		logic [1:0] pay_kind;
		logic [7:0] pay_byte;
		logic       pay_olast;
		logic       stat_v;
		logic [1:0] stat;
	} bundle_t;

endpackage

`default_nettype wire

[rtl/dloe_if.sv]
`default_nettype none

interface dloe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       packet_last;

	modport source (output valid, output data_byte, output packet_last, input ready);
	modport sink (input valid, input data_byte, input packet_last, output ready);
endinterface

interface dloe_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload;
	logic       option_last;
	logic [1:0] status;
	logic       run_last;

	modport source (output valid, output kind, output payload, output option_last,
		output status, output run_last, input ready);
	modport sink (input valid, input kind, input payload, input option_last,
		input status, input run_last, output ready);
endinterface

`default_nettype wire

[rtl/dhcp_location_option_extractor_unit.sv]
// A result is written into the result queue at the edge that accepts its item and is
// offered on the result port once it reaches the queue head.
// Throughput: one item per cycle while the result queue has room; an item with a payload
// byte and a status is sent as two results on the result port, payload first, and input
// stalls while the queue is full.
// Reset: arst_n clears parser state and the queue at once and loads the registers with
// their defaults; no clearing pass.
`default_nettype none

module dhcp_location_option_extractor_unit
	import dloe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dloe_in_if.sink          in_ch,
	dloe_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t    cfg_q;
	logic    wr_en;
	logic    push, pop, full, head_valid;
	bundle_t push_data, head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cookie     <= COOKIE_RESET;
			cfg_q.geo_code   <= GEO_RESET;
			cfg_q.civic_code <= CIVIC_RESET;
			cfg_q.min_len    <= MIN_LEN_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_COOKIE:  cfg_q.cookie     <= pwdata;
				REG_GEO:     cfg_q.geo_code   <= pwdata[7:0];
				REG_CIVIC:   cfg_q.civic_code <= pwdata[7:0];
				REG_MIN_LEN: cfg_q.min_len    <= pwdata[7:0];
				default:     cfg_q.cookie     <= cfg_q.cookie;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COOKIE:  prdata = cfg_q.cookie;
			REG_GEO:     prdata = {24'd0, cfg_q.geo_code};
			REG_CIVIC:   prdata = {24'd0, cfg_q.civic_code};
			REG_MIN_LEN: prdata = {24'd0, cfg_q.min_len};
			default:     prdata = 32'd0;
		endcase
	end

	dloe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_ch     (in_ch),
		.q_full    (full),
		.push      (push),
		.push_data (push_data)
	);

	dloe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	dloe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

`default_nettype wire

[rtl/dloe_front.sv]
`default_nettype none

module dloe_front
	import dloe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	dloe_in_if.sink      in_ch,
	input  wire logic    q_full,
	output logic         push,
	output bundle_t      push_data
);

	phase_t      phase_q, phase_d;
	cap_t        cap_q, cap_d;
	logic [23:0] win_q;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  rem_q, rem_d, rem_dec;
	logic        found_q, found_d;
	logic        accept;
	logic [7:0]  b;

	assign b           = in_ch.data_byte;
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign rem_dec     = rem_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		cap_d     = cap_q;
		rem_d     = rem_q;
		found_d   = found_q;
		push_data = '0;
		unique case (phase_q)
			PH_SEARCH: begin
				if (cnt_q >= WINDOW_FILL && {win_q, b} == cfg.cookie) phase_d = PH_CODE;
			end
			PH_CODE: begin
				priority if (b == END_OPTION) begin
					phase_d = PH_DONE;
				end else if (b == cfg.geo_code) begin
					cap_d   = CAP_GEO;
					phase_d = PH_LEN;
				end else if (b == cfg.civic_code) begin
					cap_d   = CAP_CIVIC;
					phase_d = PH_LEN;
				end else if (b == PAD_OPTION) begin
					phase_d = PH_CODE;
				end else begin
					cap_d   = CAP_NONE;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				rem_d = b;
				if (b == 8'd0) begin
					if (cap_q != CAP_NONE) found_d = 1'b1;
					cap_d   = CAP_NONE;
					phase_d = PH_CODE;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (cap_q != CAP_NONE) begin
					push_data.pay_v     = 1'b1;
					push_data.pay_kind  = (cap_q == CAP_GEO) ? KIND_GEO : KIND_CIVIC;
					push_data.pay_byte  = b;
					push_data.pay_olast = (rem_q == 8'd1);
				end
				rem_d = rem_dec;
				if (rem_dec == 8'd0) begin
					if (cap_q != CAP_NONE) found_d = 1'b1;
					cap_d   = CAP_NONE;
					phase_d = PH_CODE;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_SEARCH;
			end
		endcase

		cnt_d = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;

		push_data.stat_v = in_ch.packet_last;
		priority if (cnt_d <= cfg.min_len || phase_d == PH_SEARCH) begin
			push_data.stat = ST_NOT_FOUND;
		end else if (phase_d == PH_DONE) begin
			push_data.stat = found_d ? ST_FOUND : ST_NOT_FOUND;
		end else begin
			push_data.stat = ST_TRUNCATED;
		end
	end

	assign push = accept && (push_data.pay_v || push_data.stat_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			cap_q   <= CAP_NONE;
			win_q   <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.packet_last) begin
				phase_q <= PH_SEARCH;
				cap_q   <= CAP_NONE;
				win_q   <= '0;
				cnt_q   <= '0;
				rem_q   <= '0;
				found_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				cap_q   <= cap_d;
				win_q   <= {win_q[15:0], b};
				cnt_q   <= cnt_d;
				rem_q   <= rem_d;
				found_q <= found_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.packet_last |=> phase_q == PH_SEARCH && cnt_q == 8'd0)
		else $error("packet state not cleared after last item");

	a_payload_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		push_data.pay_v |-> phase_q == PH_DATA && cap_q != CAP_NONE)
		else $error("payload result outside a captured option");

endmodule

`default_nettype wire

[rtl/dloe_queue.sv]
`default_nettype none

module dloe_queue
	import dloe_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	input  wire logic    pop,
	output bundle_t      head,
	output logic         head_valid,
	output logic         full
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	bundle_t       mem_q [DEPTH];
	logic [IW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign head       = mem_q[rd_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == DEPTH_C);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + IW'(1);
			if (pop) rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + IW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C && !(push && full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue underflow");

endmodule

`default_nettype wire

[rtl/dloe_back.sv]
`default_nettype none

module dloe_back
	import dloe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t head,
	input  wire logic    head_valid,
	output logic         pop,
	dloe_out_if.source   out_ch
);

	logic sent_q;
	logic pay_turn;
	logic take;

	assign pay_turn = head.pay_v && !sent_q;
	assign take     = out_ch.valid && out_ch.ready;
	assign pop      = take && out_ch.run_last;

	always_comb begin
		out_ch.valid = head_valid;
		if (pay_turn) begin
			out_ch.kind        = head.pay_kind;
			out_ch.payload     = head.pay_byte;
			out_ch.option_last = head.pay_olast;
			out_ch.status      = ST_FOUND;
			out_ch.run_last    = !head.stat_v;
		end else begin
			out_ch.kind        = KIND_STATUS;
			out_ch.payload     = 8'd0;
			out_ch.option_last = 1'b0;
			out_ch.status      = head.stat;
			out_ch.run_last    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= 1'b0;
		end else if (take) begin
			sent_q <= !out_ch.run_last;
		end
	end

	a_split_order: assert property (@(posedge clk) disable iff (!arst_n)
		take && !out_ch.run_last |=> out_ch.valid && out_ch.kind == KIND_STATUS)
		else $error("status result did not follow its payload result");

endmodule

`default_nettype wire
